>>> rtl/deq_pkg.sv
package deq_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned OP_W          = 2;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned OCC_W_DEFAULT = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_REAR  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

>>> rtl/deq_if.sv
interface deq_req_if
   import deq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
   #(parameter int unsigned OCC_W = OCC_W_DEFAULT)
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output data, output status, output occupancy, input ready);
   modport sink (input valid, input data, input status, input occupancy, output ready);
endinterface

>>> rtl/deq_ram.sv
module deq_ram
   import deq_pkg::*;
   #(
   parameter int unsigned DEPTH  = DEPTH_DEFAULT,
   parameter int unsigned ADDR_W = 4
   ) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a single-port synchronous
// RAM of DEPTH entries, with wrapping front and rear pointers and an occupancy
// counter kept in flops. Each request (push rear, push front, pop front, pop
// rear) takes at most one RAM access, so one request is accepted every cycle
// while req.ready is high; its response is presented in the cycle after
// acceptance, when the registered RAM read port has the popped word. req.ready
// is low only while a response sits unaccepted in the output register and
// rsp.ready is low. A push to a full queue answers status full with data 0, a
// pop from an empty queue answers status empty with data -1; neither changes
// the contents. Every response carries the occupancy after the request. The
// RAM needs no clearing after reset, so requests are taken once reset is low.
module double_ended_queue
   import deq_pkg::*;
   #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int unsigned OCC_W = $clog2(DEPTH + 1)
   ) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req,
   deq_rsp_if.source  rsp
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] rear_ff, rear_in;
   logic [OCC_W-1:0] count_ff, count_in;

   logic             out_valid_ff;
   status_type       status_ff, status_in;
   logic [OCC_W-1:0] occ_ff;
   logic             sel_mem_ff, sel_mem_in;
   logic             fill_ff, fill_in;

   logic             take;
   logic             wr_en;
   logic             rd_en;
   logic [PTR_W-1:0] addr;
   logic [DATA_W-1:0] rd_data;
   logic             full;
   logic             empty;
   op_type           op;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   assign req.ready = !out_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign op        = op_type'(req.operation);
   assign full      = (count_ff == OCC_FULL);
   assign empty     = (count_ff == '0);

   always_comb begin
      front_in   = front_ff;
      rear_in    = rear_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      addr       = rear_ff;
      status_in  = ST_DONE;
      sel_mem_in = 1'b0;
      fill_in    = 1'b0;
      case (op)
         OP_PUSH_REAR: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = take;
               addr     = rear_ff;
               rear_in  = ptr_inc(rear_ff);
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = take;
               addr     = ptr_dec(front_ff);
               front_in = ptr_dec(front_ff);
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
               fill_in   = 1'b1;
            end else begin
               rd_en      = take;
               sel_mem_in = 1'b1;
               addr       = front_ff;
               front_in   = ptr_inc(front_ff);
               count_in   = count_ff - 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (empty) begin
               status_in = ST_EMPTY;
               fill_in   = 1'b1;
            end else begin
               rd_en      = take;
               sel_mem_in = 1'b1;
               addr       = ptr_dec(rear_ff);
               rear_in    = ptr_dec(rear_ff);
               count_in   = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   deq_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (addr),
      .wr_data (req.value),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            front_ff     <= front_in;
            rear_ff      <= rear_in;
            count_ff     <= count_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with the request
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff  <= status_in;
         occ_ff     <= count_in;
         sel_mem_ff <= sel_mem_in;
         fill_ff    <= fill_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.data      = sel_mem_ff ? rd_data : {DATA_W{fill_ff}};
   assign rsp.status    = status_ff;
   assign rsp.occupancy = occ_ff;

endmodule

>>> rtl/deq_checker.sv
module deq_checker
   import deq_pkg::*;
   #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned OCC_W = $clog2(DEPTH + 1)
   ) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DATA_W-1:0]   rsp_data,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [OCC_W-1:0]    rsp_occupancy
);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // occupancy never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OCC_W'(DEPTH))
      else $error("full refusal while not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0 && (&rsp_data))
      else $error("empty refusal with wrong data or occupancy");

   // a request taken always leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

bind double_ended_queue deq_checker #(
   .DEPTH (DEPTH),
   .OCC_W (OCC_W)
) u_deq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_data      (rsp.data),
   .rsp_status    (rsp.status),
   .rsp_occupancy (rsp.occupancy)
);
